FILE: hw/rtl/rpn_pkg.sv
package rpn_pkg;

  localparam int DEF_STACK_DEPTH   = 64;
  localparam int DEF_NUM_VARIABLES = 256;
  localparam int DEF_FRAC_BITS     = 16;
  localparam int W                 = 48;

  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_VARID = 2'd1;
  localparam logic [1:0] REQ_OP    = 2'd2;
  localparam logic [1:0] REQ_STORE = 2'd3;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_SUB     = 3'd1;
  localparam logic [2:0] OP_MUL     = 3'd2;
  localparam logic [2:0] OP_DIV     = 3'd3;
  localparam logic [2:0] OP_MOD     = 3'd4;
  localparam logic [2:0] OP_TRUNC   = 3'd5;
  localparam logic [2:0] OP_FETCH   = 3'd6;
  localparam logic [2:0] OP_INVALID = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DIVZERO  = 3'd1;
  localparam logic [2:0] ST_UNDER    = 3'd2;
  localparam logic [2:0] ST_OVER     = 3'd3;
  localparam logic [2:0] ST_UNKVAR   = 3'd4;
  localparam logic [2:0] ST_BADDEPTH = 3'd5;
  localparam logic [2:0] ST_BADOP    = 3'd6;

  typedef struct packed {
    logic [1:0]        req_type;
    logic signed [W-1:0] value;
    logic [7:0]        var_id;
    logic [2:0]        op_code;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic signed [W-1:0] result_value;
    logic [2:0]          status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_B, S_RD_A, S_WAIT, S_EXEC, S_FETCH, S_MUL, S_DIV, S_PUSH,
    S_FINISH, S_RD_0, S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load_item;   // capture input item
    logic       store_var;   // variable table write
    logic       rd_top;      // read stack at depth-1, pop
    logic       cap_b;       // latch read data as b
    logic       cap_a;       // latch read data as a
    logic       fetch_rd;    // read variable table at a
    logic       mul_start;
    logic       div_start;
    logic       push_res;    // push result register
    logic       push_in;     // push from item
    logic       rd_bottom;   // read entry 0
    logic       set_err;
    logic [2:0] err_code;
    logic       clear_expr;
    logic       out_load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic       full;
    logic       depth_ge1;
    logic       depth_ge2;
    logic       depth_one;
    logic       err_set;
    logic       b_zero;
    logic       ib_zero;
    logic       var_ok;
    logic       mul_done;
    logic       div_done;
  } sts_t;

endpackage

FILE: hw/rtl/rpn_stack_evaluator.sv
// Postfix expression evaluator on signed Q32.16 values. Each input item is one
// element: push value, push variable id, apply operator or store a variable.
// One item is handled at a time. Multiply sums four 24x24 partial products
// through one multiplier; divide and modulo give one quotient bit a cycle over
// 48 + FRAC_BITS bits. An item marked last waits for any earlier result item
// still held, then gives one result item with the single stack value and a
// status; errors latch until then. The result waits in an output register.
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH   = rpn_pkg::DEF_STACK_DEPTH,
  parameter int NUM_VARIABLES = rpn_pkg::DEF_NUM_VARIABLES,
  parameter int FRAC_BITS     = rpn_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rpn_pkg::out_item_t out_data
);
  import rpn_pkg::*;

  ctl_t ctl;
  sts_t sts;

  rpn_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .item(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .ctl(ctl)
  );

  rpn_dp #(
    .STACK_DEPTH(STACK_DEPTH), .NUM_VARIABLES(NUM_VARIABLES),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .item(in_data), .ctl(ctl), .sts(sts), .result(out_data)
  );

endmodule

FILE: hw/rtl/rpn_ctrl.sv
module rpn_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rpn_pkg::in_item_t item,
  output logic            out_valid,
  input  logic            out_ready,
  input  rpn_pkg::sts_t   sts,
  output rpn_pkg::ctl_t   ctl
);
  import rpn_pkg::*;

  state_t   state, state_next;
  in_item_t cur;
  logic     ovalid, ovalid_next;

  // item register for decode
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
  end

  assign out_valid = ovalid;
  assign in_ready  = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next  = state;
    ovalid_next = ovalid && !out_ready;
    ctl         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_item = 1'b1;
          state_next    = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_FINISH;
        if (cur.req_type == REQ_STORE) begin
          ctl.store_var = 1'b1;
        end else if (!sts.err_set) begin
          if (cur.req_type != REQ_OP) begin
            if (sts.full) begin
              ctl.set_err  = 1'b1;
              ctl.err_code = ST_OVER;
            end else begin
              ctl.push_in = 1'b1;
            end
          end else if (cur.op_code == OP_INVALID) begin
            ctl.set_err  = 1'b1;
            ctl.err_code = ST_BADOP;
          end else if (cur.op_code == OP_TRUNC || cur.op_code == OP_FETCH) begin
            if (!sts.depth_ge1) begin
              ctl.set_err  = 1'b1;
              ctl.err_code = ST_UNDER;
            end else begin
              ctl.rd_top = 1'b1;
              state_next = S_RD_A;
            end
          end else if (!sts.depth_ge2) begin
            ctl.set_err  = 1'b1;
            ctl.err_code = ST_UNDER;
          end else begin
            ctl.rd_top = 1'b1;
            state_next = S_RD_B;
          end
        end
      end
      S_RD_B: begin
        ctl.cap_b  = 1'b1;
        ctl.rd_top = 1'b1;
        state_next = S_RD_A;
      end
      S_RD_A: begin
        ctl.cap_a  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_PUSH;
        unique case (cur.op_code)
          OP_MUL: begin
            ctl.mul_start = 1'b1;
            state_next    = S_MUL;
          end
          OP_DIV: begin
            if (sts.b_zero) begin
              ctl.set_err  = 1'b1;
              ctl.err_code = ST_DIVZERO;
              state_next   = S_FINISH;
            end else begin
              ctl.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end
          OP_MOD: begin
            if (sts.ib_zero) begin
              ctl.set_err  = 1'b1;
              ctl.err_code = ST_DIVZERO;
              state_next   = S_FINISH;
            end else begin
              ctl.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end
          OP_FETCH: begin
            if (!sts.var_ok) begin
              ctl.set_err  = 1'b1;
              ctl.err_code = ST_UNKVAR;
              state_next   = S_FINISH;
            end else begin
              ctl.fetch_rd = 1'b1;
              state_next   = S_FETCH;
            end
          end
          default: ;
        endcase
      end
      S_FETCH: state_next = S_PUSH;
      S_MUL: if (sts.mul_done) state_next = S_PUSH;
      S_DIV: if (sts.div_done) state_next = S_PUSH;
      S_PUSH: begin
        ctl.push_res = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (!cur.last) begin
          state_next = S_IDLE;
        end else if (!ovalid || out_ready) begin
          ctl.rd_bottom = 1'b1;
          state_next    = S_RD_0;
        end
      end
      S_RD_0: state_next = S_OUT;
      S_OUT: begin
        ctl.out_load   = 1'b1;
        ctl.clear_expr = 1'b1;
        ovalid_next    = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/rpn_mul.sv
module rpn_mul #(
  parameter int FRAC_BITS = rpn_pkg::DEF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [rpn_pkg::W-1:0]  ma,
  input  logic [rpn_pkg::W-1:0]  mb,
  input  logic                   neg,
  output logic                   done,
  output logic [rpn_pkg::W-1:0]  res
);
  import rpn_pkg::*;

  localparam int PW = 2 * W;
  localparam logic [PW-1:0] POS_LIM = PW'({1'b0, {(W-1){1'b1}}});
  localparam logic [PW-1:0] NEG_LIM = PW'({1'b1, {(W-1){1'b0}}});

  // four 24x24 partial products, one a cycle
  logic [1:0]    step;
  logic          busy;
  logic [PW-1:0] acc;
  logic [23:0]   pa, pb;
  logic [47:0]   prod;
  logic [PW-1:0] scaled;

  always_comb begin
    pa     = step[1] ? ma[47:24] : ma[23:0];
    pb     = step[0] ? mb[47:24] : mb[23:0];
    prod   = pa * pb;
    scaled = acc >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
        acc  <= '0;
      end else if (busy) begin
        acc  <= acc + (PW'(prod) << (24 * (32'(step[1]) + 32'(step[0]))));
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturate after scaling
  always_comb begin
    if (neg) begin
      res = (scaled >= NEG_LIM) ? {1'b1, {(W-1){1'b0}}} : W'(-scaled);
    end else begin
      res = (scaled > POS_LIM) ? {1'b0, {(W-1){1'b1}}} : scaled[W-1:0];
    end
  end

endmodule

FILE: hw/rtl/rpn_div.sv
module rpn_div #(
  parameter int FRAC_BITS = rpn_pkg::DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  is_mod,
  input  logic [rpn_pkg::W-1:0] ma,
  input  logic [rpn_pkg::W-1:0] mb,
  input  logic                  neg_q,
  input  logic                  neg_r,
  output logic                  done,
  output logic [rpn_pkg::W-1:0] res
);
  import rpn_pkg::*;

  localparam int NW = W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  // restoring divider, one quotient bit per cycle
  logic [NW-1:0] num;
  logic [NW-1:0] quo;
  logic [W:0]    rem;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy, mode_mod;
  logic [W:0]    trial;
  logic [W-1:0]  rres;

  assign trial = {rem[W-1:0], num[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        mode_mod <= is_mod;
        rem      <= '0;
        quo      <= '0;
        cnt      <= CW'(NW);
        if (is_mod) begin
          num <= NW'(ma >> FRAC_BITS);
          dvs <= mb >> FRAC_BITS;
        end else begin
          num <= NW'(ma) << FRAC_BITS;
          dvs <= mb;
        end
      end else if (busy) begin
        num <= num << 1;
        if (trial >= {1'b0, dvs}) begin
          rem <= trial - {1'b0, dvs};
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // sign and saturation of the result
  always_comb begin
    rres = W'(rem[W-1:0] << FRAC_BITS);
    if (mode_mod) begin
      res = neg_r ? W'(-rres) : rres;
    end else if (neg_q) begin
      res = (NW'(quo) >= NW'({1'b1, {(W-1){1'b0}}})) ? {1'b1, {(W-1){1'b0}}}
          : W'(-quo);
    end else begin
      res = (NW'(quo) > NW'({1'b0, {(W-1){1'b1}}})) ? {1'b0, {(W-1){1'b1}}}
          : quo[W-1:0];
    end
  end

endmodule

FILE: hw/rtl/rpn_dp.sv
module rpn_dp #(
  parameter int STACK_DEPTH   = rpn_pkg::DEF_STACK_DEPTH,
  parameter int NUM_VARIABLES = rpn_pkg::DEF_NUM_VARIABLES,
  parameter int FRAC_BITS     = rpn_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  rpn_pkg::in_item_t  item,
  input  rpn_pkg::ctl_t      ctl,
  output rpn_pkg::sts_t      sts,
  output rpn_pkg::out_item_t result
);
  import rpn_pkg::*;

  localparam int SA = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int VA = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;
  localparam logic [W-1:0] FMASK = W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [W-1:0] POSMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEGMIN = {1'b1, {(W-1){1'b0}}};

  in_item_t          cur;
  logic [W-1:0]      stack_mem [STACK_DEPTH];
  logic [W-1:0]      var_mem [NUM_VARIABLES];
  logic [NUM_VARIABLES-1:0] var_valid;
  logic [W-1:0]      srd, vrd;
  logic [DW-1:0]     depth;
  logic [2:0]        err;
  logic signed [W-1:0] a, b;
  logic [W-1:0]      r, ma, mb;
  logic              mul_done, div_done;
  logic [W-1:0]      mul_res, div_res;
  logic [W:0]        sum;
  logic [W-1:0]      alu;
  logic [DW-1:0]     wr_ptr;
  logic [W-1:0]      wr_data;
  logic              wr_en;
  logic [DW-1:0]     rd_ptr;
  logic              fetch_pend;

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cur <= item;
    end
  end

  // stack memory, one write and one registered read
  always_comb begin
    wr_en   = ctl.push_in || ctl.push_res;
    wr_ptr  = depth;
    wr_data = ctl.push_in ? ((cur.req_type == REQ_PUSH) ? cur.value : W'(cur.var_id)) : r;
    rd_ptr  = ctl.rd_bottom ? '0 : depth - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_ptr[SA-1:0]] <= wr_data;
    end
    srd <= stack_mem[rd_ptr[SA-1:0]];
  end

  // variable table
  always_ff @(posedge clk) begin
    if (ctl.store_var && 32'(cur.var_id) < NUM_VARIABLES) begin
      var_mem[VA'(cur.var_id)] <= cur.value;
    end
    vrd <= var_mem[a[VA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      var_valid <= '0;
    end else if (ctl.store_var && 32'(cur.var_id) < NUM_VARIABLES) begin
      var_valid[VA'(cur.var_id)] <= 1'b1;
    end
  end

  // depth and error latch
  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      err   <= ST_OK;
    end else if (ctl.clear_expr) begin
      depth <= '0;
      err   <= ST_OK;
    end else begin
      if (ctl.set_err) err <= ctl.err_code;
      if (ctl.rd_top) depth <= depth - 1'b1;
      else if (wr_en) depth <= depth + 1'b1;
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (ctl.cap_b) b <= srd;
    if (ctl.cap_a) a <= srd;
  end

  assign ma = a[W-1] ? W'(-a) : a;
  assign mb = b[W-1] ? W'(-b) : b;

  rpn_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .start(ctl.mul_start), .ma(ma), .mb(mb),
    .neg(a[W-1] ^ b[W-1]), .done(mul_done), .res(mul_res)
  );

  rpn_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(ctl.div_start), .is_mod(cur.op_code == OP_MOD),
    .ma(ma), .mb(mb), .neg_q(a[W-1] ^ b[W-1]), .neg_r(a[W-1]),
    .done(div_done), .res(div_res)
  );

  // add, subtract, truncate
  always_comb begin
    sum = (cur.op_code == OP_SUB) ? ({a[W-1], a} - {b[W-1], b})
                                  : ({a[W-1], a} + {b[W-1], b});
    if (sum[W] != sum[W-1]) alu = sum[W] ? NEGMIN : POSMAX;
    else alu = sum[W-1:0];
    if (cur.op_code == OP_TRUNC) begin
      alu = a[W-1] ? W'(-(ma & ~FMASK)) : (ma & ~FMASK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_pend <= 1'b0;
    end else begin
      fetch_pend <= ctl.fetch_rd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.cap_a) r <= '0;
    else if (mul_done) r <= mul_res;
    else if (div_done) r <= div_res;
    else if (fetch_pend) r <= vrd;
    else if (ctl.mul_start || ctl.div_start || ctl.fetch_rd) r <= r;
    else if (ctl.set_err == 1'b0 && !ctl.push_res) r <= alu;
  end

  // output item register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      if (err != ST_OK) begin
        result.result_value <= '0;
        result.status       <= err;
      end else if (depth != DW'(1)) begin
        result.result_value <= '0;
        result.status       <= ST_BADDEPTH;
      end else begin
        result.result_value <= srd;
        result.status       <= ST_OK;
      end
    end
  end

  always_comb begin
    sts.full      = (depth >= DW'(STACK_DEPTH));
    sts.depth_ge1 = (depth != '0);
    sts.depth_ge2 = (depth >= DW'(2));
    sts.depth_one = (depth == DW'(1));
    sts.err_set   = (err != ST_OK);
    sts.b_zero    = (b == '0);
    sts.ib_zero   = ((mb >> FRAC_BITS) == '0);
    sts.var_ok    = (a < W'(NUM_VARIABLES)) && a >= 0 && var_valid[a[VA-1:0]];
    sts.mul_done  = mul_done;
    sts.div_done  = div_done;
  end

endmodule

FILE: tb/rpn_checker.sv
module rpn_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  rpn_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  rpn_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);
  import rpn_pkg::*;

  localparam int SDEPTH = 64;
  localparam int NVARS  = 256;
  localparam int FRAC   = 16;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] eval_stack [SDEPTH];
  int                  eval_depth;
  logic [2:0]          eval_err;
  logic signed [W-1:0] var_table [NVARS];
  logic                var_written [NVARS];
  out_item_t           result_queue [$];

  // saturate a wide signed value to 48 bits
  function automatic logic signed [W-1:0] sat(input logic signed [127:0] v);
    if (v > 128'(MAXV)) return MAXV;
    if (v < 128'(MINV)) return MINV;
    return v[W-1:0];
  endfunction

  function automatic logic [127:0] magn(input logic signed [W-1:0] v);
    logic signed [127:0] e;
    e = v;
    return e < 0 ? -e : e;
  endfunction

  // signed value from magnitude, saturated
  function automatic logic signed [W-1:0] signed_sat(input logic [127:0] m, input logic neg);
    logic signed [127:0] s;
    if (m[127]) return neg ? MINV : MAXV;
    s = neg ? -$signed(m) : $signed(m);
    return sat(s);
  endfunction

  function automatic void push_val(input logic signed [W-1:0] v);
    if (eval_depth >= SDEPTH) eval_err = ST_OVER;
    else begin
      eval_stack[eval_depth] = v;
      eval_depth++;
    end
  endfunction

  // apply one operator to the stack
  function automatic void apply_operator(input logic [2:0] op);
    logic signed [W-1:0] a, b, r;
    logic [127:0] ma, mb, m, ia, ib;
    logic [W-1:0] id;
    if (op == OP_INVALID) begin
      eval_err = ST_BADOP;
      return;
    end
    if (op == OP_TRUNC || op == OP_FETCH) begin
      if (eval_depth < 1) begin
        eval_err = ST_UNDER;
        return;
      end
      eval_depth--;
      a = eval_stack[eval_depth];
      if (op == OP_TRUNC) begin
        m = magn(a);
        m[FRAC-1:0] = '0;
        r = a < 0 ? -$signed(m[W-1:0]) : m[W-1:0];
      end else begin
        id = a;
        if (id >= NVARS || !var_written[id[7:0]]) begin
          eval_err = ST_UNKVAR;
          return;
        end
        r = var_table[id[7:0]];
      end
      push_val(r);
      return;
    end
    if (eval_depth < 2) begin
      eval_err = ST_UNDER;
      return;
    end
    eval_depth--;
    b = eval_stack[eval_depth];
    eval_depth--;
    a = eval_stack[eval_depth];
    ma = magn(a);
    mb = magn(b);
    case (op)
      OP_ADD: r = sat(128'(a) + 128'(b));
      OP_SUB: r = sat(128'(a) - 128'(b));
      OP_MUL: r = signed_sat((ma * mb) >> FRAC, (a < 0) != (b < 0));
      OP_DIV: begin
        if (b == 0) begin
          eval_err = ST_DIVZERO;
          return;
        end
        r = signed_sat((ma << FRAC) / mb, (a < 0) != (b < 0));
      end
      default: begin
        ia = ma >> FRAC;
        ib = mb >> FRAC;
        if (ib == 0) begin
          eval_err = ST_DIVZERO;
          return;
        end
        m = (ia % ib) << FRAC;
        r = a < 0 ? -$signed(m[W-1:0]) : m[W-1:0];
      end
    endcase
    push_val(r);
  endfunction

  // model one accepted element
  function automatic void evaluate_element(input in_item_t it);
    out_item_t res;
    if (it.req_type == REQ_STORE) begin
      var_table[it.var_id] = it.value;
      var_written[it.var_id] = 1'b1;
    end else if (eval_err == ST_OK) begin
      case (it.req_type)
        REQ_PUSH:  push_val(it.value);
        REQ_VARID: push_val(W'(it.var_id));
        default:   apply_operator(it.op_code);
      endcase
    end
    if (!it.last) return;
    if (eval_err == ST_OK && eval_depth != 1) eval_err = ST_BADDEPTH;
    res.result_value = eval_err == ST_OK ? eval_stack[0] : '0;
    res.status = eval_err;
    result_queue.push_back(res);
    eval_depth = 0;
    eval_err = ST_OK;
  endfunction

  assign pending = result_queue.size();

  // watch both channels
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      eval_depth = 0;
      eval_err = ST_OK;
      for (int i = 0; i < NVARS; i++) var_written[i] = 1'b0;
      result_queue.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result item %h", out_data);
        end else begin
          want = result_queue.pop_front();
          if (want.result_value !== out_data.result_value ||
              want.status !== out_data.status) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected value %h status %0d, got value %h status %0d",
                       want.result_value, want.status, out_data.result_value,
                       out_data.status);
          end
        end
      end
      if (in_valid && in_ready) evaluate_element(in_data);
    end
  end
endmodule

FILE: tb/tb_rpn_stack_evaluator.sv
module tb_rpn_stack_evaluator;
  import rpn_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        send_idle = 0;
  int        recv_idle = 0;
  logic      hold_off = 1'b0;
  logic      stim_done = 1'b0;

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE  = 48'sh10000;

  rpn_stack_evaluator uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  rpn_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one item and wait for it to be taken
  task automatic send_item(input logic [1:0] kind, input logic signed [W-1:0] v,
                           input logic [7:0] id, input logic [2:0] op, input logic lst);
    in_item_t it;
    it.req_type = kind;
    it.value = v;
    it.var_id = id;
    it.op_code = op;
    it.last = lst;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic push_value(input logic signed [W-1:0] v, input logic lst);
    send_item(REQ_PUSH, v, 8'($urandom), 3'($urandom), lst);
  endtask

  task automatic apply_op(input logic [2:0] op, input logic lst);
    send_item(REQ_OP, 48'({$urandom, $urandom}), 8'($urandom), op, lst);
  endtask

  // random operand, often small, sometimes at the edges
  function automatic logic signed [W-1:0] rand_operand();
    case ($urandom_range(7))
      0: return MAXV;
      1: return MINV;
      2: return 48'({$urandom, $urandom});
      3: return 48'($signed($urandom_range(0, 200) - 100)) <<< 16;
      4: return '0;
      default: return 48'($signed($urandom_range(0, 40000000) - 20000000)) <<< $urandom_range(4);
    endcase
  endfunction

  // well-formed random expression, with occasional noise
  task automatic random_expression(output int count);
    int depth;
    int n;
    logic [2:0] op;
    depth = 0;
    count = 0;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        send_item(2'($urandom), 48'({$urandom, $urandom}), 8'($urandom), 3'($urandom),
                  1'b0);
      end else if (depth >= 2 && $urandom_range(1)) begin
        op = 3'($urandom_range(OP_MOD));
        apply_op(op, 1'b0);
        depth--;
      end else if (depth >= 1 && $urandom_range(3) == 0) begin
        apply_op($urandom_range(1) ? OP_TRUNC : OP_FETCH, 1'b0);
      end else if ($urandom_range(4) == 0) begin
        send_item(REQ_VARID, 48'({$urandom, $urandom}), 8'($urandom_range(15)),
                  3'($urandom), 1'b0);
        depth++;
      end else begin
        push_value(rand_operand(), 1'b0);
        depth++;
      end
      count++;
    end
    while (depth > 1 && $urandom_range(7) != 0) begin
      apply_op(3'($urandom_range(OP_MOD)), 1'b0);
      depth--;
      count++;
    end
    if ($urandom_range(1)) apply_op(3'($urandom_range(OP_MOD)), 1'b1);
    else push_value(rand_operand(), 1'b1);
    count++;
  endtask

  // receiver readiness
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= $urandom_range(99) >= recv_idle;
  end

  // stimulus
  initial begin
    int cnt;
    int total;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: arithmetic on extremes
    push_value(MAXV, 1'b0); push_value(ONE, 1'b0); apply_op(OP_ADD, 1'b1);
    push_value(MINV, 1'b0); push_value(ONE, 1'b0); apply_op(OP_SUB, 1'b1);
    push_value(MAXV, 1'b0); push_value(MAXV, 1'b0); apply_op(OP_MUL, 1'b1);
    push_value(MINV, 1'b0); push_value(48'sd1, 1'b0); apply_op(OP_DIV, 1'b1);
    push_value(ONE, 1'b0); push_value(48'sd0, 1'b0); apply_op(OP_DIV, 1'b1);
    push_value(-48'sd1 <<< 20, 1'b0); push_value(48'sd3 <<< 16, 1'b0);
    apply_op(OP_MOD, 1'b1);
    // modulo divisor zero only after truncation
    push_value(ONE, 1'b0); push_value(48'sh8000, 1'b0); apply_op(OP_MOD, 1'b1);
    push_value(-48'sd98765, 1'b0); apply_op(OP_TRUNC, 1'b1);
    // stores and fetches, including unknown variable
    send_item(REQ_STORE, MINV, 8'd255, OP_ADD, 1'b0);
    send_item(REQ_VARID, '0, 8'd255, OP_ADD, 1'b0); apply_op(OP_FETCH, 1'b1);
    send_item(REQ_VARID, '0, 8'd200, OP_ADD, 1'b0); apply_op(OP_FETCH, 1'b1);
    push_value(48'sd300, 1'b0); apply_op(OP_FETCH, 1'b1);
    // underflow, bad opcode, bad depth, store during error
    apply_op(OP_ADD, 1'b1);
    push_value(ONE, 1'b0); apply_op(OP_INVALID, 1'b0);
    send_item(REQ_STORE, ONE, 8'd1, OP_ADD, 1'b1);
    push_value(ONE, 1'b0); push_value(ONE, 1'b1);
    // overflow: more than a full stack
    for (int i = 0; i < 66; i++) push_value(48'(i), i == 65);

    // store a few variables for fetches
    for (int i = 0; i < 16; i++) send_item(REQ_STORE, rand_operand(), 8'(i), OP_ADD, 1'b0);

    // random phases
    total = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 36 : ph == 1 ? 53 : 0;
      recv_idle = ph == 0 ? 53 : ph == 1 ? 36 : 0;
      if (ph == 2) begin
        fork
          begin
            hold_off <= 1'b1;
            repeat (3000) @(posedge clk);
            hold_off <= 1'b0;
          end
        join_none
      end
      while (total < (ph + 1) * 280) begin
        random_expression(cnt);
        total += cnt;
      end
    end
    in_valid <= 1'b0;
    stim_done <= 1'b1;
  end

  // verdict
  initial begin
    @(posedge stim_done);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("** rpn_stack_evaluator: PASSED **");
    else $display("** rpn_stack_evaluator: FAILED **");
    $finish;
  end

  initial begin
    #5000000;
    $display("** rpn_stack_evaluator: FAILED **");
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_ctrl.sv
hw/rtl/rpn_mul.sv
hw/rtl/rpn_div.sv
hw/rtl/rpn_dp.sv
hw/rtl/rpn_stack_evaluator.sv
tb/rpn_checker.sv
tb/tb_rpn_stack_evaluator.sv
